### rtl/core/attitude_pi_rate_controller_top_defines.svh
// ----------------------------------------------------------------------------
// attitude_pi_rate_controller_top_defines
// assertion macros shared by the controller rtl
// ----------------------------------------------------------------------------
`ifndef ATTITUDE_PI_RATE_CONTROLLER_TOP_DEFINES_SVH
`define ATTITUDE_PI_RATE_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define APR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define APR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// types and constants of the three-axis attitude pi rate controller
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int unsigned ARM_THRESHOLD_US = 1020;
    localparam int unsigned STICK_CENTER_US  = 1500;

    // floor(2^20 / 25), quotient is exact after one correction step
    localparam logic [15:0] RECIP_25 = 16'd41943;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_ROLL  = 2'd0;
    localparam axis_t AXIS_PITCH = 2'd1;
    localparam axis_t AXIS_YAW   = 2'd2;

    typedef logic [2:0] mul_op_t;
    localparam mul_op_t MUL_RECIP = 3'd0;
    localparam mul_op_t MUL_TICK  = 3'd1;
    localparam mul_op_t MUL_KI    = 3'd2;
    localparam mul_op_t MUL_KP    = 3'd3;
    localparam mul_op_t MUL_KD    = 3'd4;

    typedef logic [1:0] acc_op_t;
    localparam acc_op_t ACC_HOLD = 2'd0;
    localparam acc_op_t ACC_LOAD = 2'd1;
    localparam acc_op_t ACC_ADD  = 2'd2;
    localparam acc_op_t ACC_SUB  = 2'd3;

    typedef logic [3:0] cfg_index_t;
    localparam cfg_index_t CFG_KP_RP  = 4'd0;
    localparam cfg_index_t CFG_KP_YAW = 4'd1;
    localparam cfg_index_t CFG_KD_RP  = 4'd2;
    localparam cfg_index_t CFG_KD_YAW = 4'd3;
    localparam cfg_index_t CFG_KI_RP  = 4'd4;
    localparam cfg_index_t CFG_KI_YAW = 4'd5;
    localparam cfg_index_t CFG_LIM_RP  = 4'd6;
    localparam cfg_index_t CFG_LIM_YAW = 4'd7;

    typedef struct packed {
        logic [15:0] kp_rp;
        logic [15:0] kp_yaw;
        logic [15:0] kd_rp;
        logic [15:0] kd_yaw;
        logic [15:0] ki_rp;
        logic [15:0] ki_yaw;
        logic [17:0] lim_rp;
        logic [17:0] lim_yaw;
    } gains_t;

    typedef struct packed {
        axis_t   axis;
        logic    in_load;
        logic    mul_en;
        mul_op_t mul_op;
        logic    quot_en;
        logic    err_en;
        logic    integ_en;
        acc_op_t acc_op;
        logic    torque_en;
        logic    out_load;
    } dp_cmd_t;

endpackage

### rtl/core/attitude_pi_rate_controller_top.sv
// sequence: accept in idle, then ten steps of the shared multiplier
// sequence per axis over three axes, then hand-off to the result register,
// which waits while a held result is stalled; no new item until hand-off
// a new item is taken while the previous result still waits in its register
// reset: gains and limits return to their defaults, integrals clear to zero
// ----------------------------------------------------------------------------
// attitude_pi_rate_controller_top
// three-axis pi angle controller with rate feedback and arming gate
// ----------------------------------------------------------------------------
module attitude_pi_rate_controller_top
    import apr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // item input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic        [11:0] rc_roll_width,
    input  logic        [11:0] rc_pitch_width,
    input  logic        [11:0] rc_throttle_width,
    input  logic        [11:0] rc_yaw_width,
    input  logic signed [16:0] roll_angle,
    input  logic signed [16:0] pitch_angle,
    input  logic signed [16:0] yaw_angle,
    input  logic signed [19:0] roll_rate,
    input  logic signed [19:0] pitch_rate,
    input  logic signed [19:0] yaw_rate,
    input  logic        [15:0] tick_length,
    // item output
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] torque_roll,
    output logic signed [23:0] torque_pitch,
    output logic signed [23:0] torque_yaw,
    output logic               motors_enabled,
    output logic        [11:0] throttle_out,
    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [3:0]  cfg_index,
    input  logic        [17:0] cfg_data
);

    gains_t  gains;
    dp_cmd_t cmd;

    apr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    apr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    apr_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .gains             (gains),
        .rc_roll_width     (rc_roll_width),
        .rc_pitch_width    (rc_pitch_width),
        .rc_throttle_width (rc_throttle_width),
        .rc_yaw_width      (rc_yaw_width),
        .roll_angle        (roll_angle),
        .pitch_angle       (pitch_angle),
        .yaw_angle         (yaw_angle),
        .roll_rate         (roll_rate),
        .pitch_rate        (pitch_rate),
        .yaw_rate          (yaw_rate),
        .tick_length       (tick_length),
        .torque_roll       (torque_roll),
        .torque_pitch      (torque_pitch),
        .torque_yaw        (torque_yaw),
        .motors_enabled    (motors_enabled),
        .throttle_out      (throttle_out)
    );

endmodule

### rtl/core/apr_cfg.sv
// ----------------------------------------------------------------------------
// apr_cfg
// gain and integral limit registers, written through the config channel
// ----------------------------------------------------------------------------
module apr_cfg
    import apr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [17:0] cfg_data,
    output gains_t      gains
);

    gains_t gains_reg;
    gains_t gains_next;

    assign cfg_ready = 1'b1;
    assign gains     = gains_reg;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KP_RP:   gains_next.kp_rp   = cfg_data[15:0];
                CFG_KP_YAW:  gains_next.kp_yaw  = cfg_data[15:0];
                CFG_KD_RP:   gains_next.kd_rp   = cfg_data[15:0];
                CFG_KD_YAW:  gains_next.kd_yaw  = cfg_data[15:0];
                CFG_KI_RP:   gains_next.ki_rp   = cfg_data[15:0];
                CFG_KI_YAW:  gains_next.ki_yaw  = cfg_data[15:0];
                CFG_LIM_RP:  gains_next.lim_rp  = cfg_data;
                CFG_LIM_YAW: gains_next.lim_yaw = cfg_data;
                default:     gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.kp_rp   <= 16'd1408;
            gains_reg.kp_yaw  <= 16'd1357;
            gains_reg.kd_rp   <= 16'd922;
            gains_reg.kd_yaw  <= 16'd410;
            gains_reg.ki_rp   <= 16'd154;
            gains_reg.ki_yaw  <= 16'd26;
            gains_reg.lim_rp  <= 18'd25600;
            gains_reg.lim_yaw <= 18'd76800;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

endmodule

### rtl/core/apr_dp.sv
// ----------------------------------------------------------------------------
// apr_dp
// datapath: one shared 32x17 multiplier, quotient fix-up, integrator, accumulator
// ----------------------------------------------------------------------------
module apr_dp
    import apr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  gains_t             gains,
    input  logic        [11:0] rc_roll_width,
    input  logic        [11:0] rc_pitch_width,
    input  logic        [11:0] rc_throttle_width,
    input  logic        [11:0] rc_yaw_width,
    input  logic signed [16:0] roll_angle,
    input  logic signed [16:0] pitch_angle,
    input  logic signed [16:0] yaw_angle,
    input  logic signed [19:0] roll_rate,
    input  logic signed [19:0] pitch_rate,
    input  logic signed [19:0] yaw_rate,
    input  logic        [15:0] tick_length,
    output logic signed [23:0] torque_roll,
    output logic signed [23:0] torque_pitch,
    output logic signed [23:0] torque_yaw,
    output logic               motors_enabled,
    output logic        [11:0] throttle_out
);

    // captured item
    logic        [11:0] roll_w_reg, pitch_w_reg, thr_w_reg, yaw_w_reg;
    logic signed [16:0] roll_a_reg, pitch_a_reg, yaw_a_reg;
    logic signed [19:0] roll_r_reg, pitch_r_reg, yaw_r_reg;
    logic        [15:0] tick_reg;

    // working registers
    logic signed [48:0] prod_reg;
    logic signed [48:0] prod_next;
    logic        [15:0] quot_reg;
    logic        [15:0] quot_next;
    logic signed [17:0] err_reg;
    logic signed [17:0] err_next;
    logic signed [49:0] acc_reg;
    logic signed [49:0] acc_next;
    logic signed [31:0] integ_reg [3];
    logic signed [31:0] integ_next;
    logic signed [23:0] torque_reg [3];
    logic signed [23:0] torque_next;

    // result registers
    logic signed [23:0] torque_roll_reg, torque_pitch_reg, torque_yaw_reg;
    logic               motors_enabled_reg;
    logic        [11:0] throttle_out_reg;

    logic               armed;
    logic               yaw;
    logic        [11:0] width_sel;
    logic signed [16:0] angle_sel;
    logic signed [19:0] rate_sel;
    logic signed [31:0] integ_sel;
    logic        [15:0] kp_sel, kd_sel, ki_sel;
    logic        [17:0] lim_sel;

    logic signed [12:0] dev;
    logic               dev_neg;
    logic        [11:0] dev_mag;
    logic        [19:0] scaled;
    logic        [19:0] num_abs;

    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_a_ext;
    logic signed [48:0] mul_b_ext;

    logic        [15:0] q_est;
    logic        [20:0] q25;
    logic        [20:0] rem;
    logic signed [16:0] ref_pos;
    logic signed [16:0] ref_val;
    logic signed [17:0] ref_ext;
    logic signed [17:0] angle_ext;

    logic signed [25:0] delta;
    logic signed [32:0] integ_sum;
    logic signed [32:0] lim_pos;
    logic signed [32:0] lim_neg;
    logic signed [32:0] integ_clamped;

    logic signed [49:0] prod_ext;
    logic signed [49:0] prod_sh;
    logic signed [29:0] torque_wide;

    assign armed = thr_w_reg > 12'(ARM_THRESHOLD_US);
    assign yaw   = (cmd.axis == AXIS_YAW);

    // per-axis operand selection
    always_comb
    begin
        unique case (cmd.axis)
            AXIS_ROLL:
            begin
                width_sel = roll_w_reg;
                angle_sel = roll_a_reg;
                rate_sel  = roll_r_reg;
                integ_sel = integ_reg[AXIS_ROLL];
            end
            AXIS_PITCH:
            begin
                width_sel = pitch_w_reg;
                angle_sel = pitch_a_reg;
                rate_sel  = pitch_r_reg;
                integ_sel = integ_reg[AXIS_PITCH];
            end
            AXIS_YAW:
            begin
                width_sel = yaw_w_reg;
                angle_sel = yaw_a_reg;
                rate_sel  = yaw_r_reg;
                integ_sel = integ_reg[AXIS_YAW];
            end
            default:
            begin
                width_sel = yaw_w_reg;
                angle_sel = yaw_a_reg;
                rate_sel  = yaw_r_reg;
                integ_sel = integ_reg[AXIS_YAW];
            end
        endcase
    end

    assign kp_sel  = yaw ? gains.kp_yaw  : gains.kp_rp;
    assign kd_sel  = yaw ? gains.kd_yaw  : gains.kd_rp;
    assign ki_sel  = yaw ? gains.ki_yaw  : gains.ki_rp;
    assign lim_sel = yaw ? gains.lim_yaw : gains.lim_rp;

    // stick deviation, |d| * 256 or |d| * 384, plus half the divisor for rounding
    assign dev     = $signed({1'b0, width_sel}) - $signed(13'(STICK_CENTER_US));
    assign dev_neg = dev[12];
    assign dev_mag = dev_neg ? 12'(-dev) : dev[11:0];
    assign scaled  = yaw ? ({dev_mag, 8'b0} + 20'({dev_mag, 7'b0})) : {dev_mag, 8'b0};
    assign num_abs = scaled + 20'd12;

    // shared multiplier operands
    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_RECIP:
            begin
                mul_a = $signed({12'b0, num_abs});
                mul_b = $signed({1'b0, RECIP_25});
            end
            MUL_TICK:
            begin
                mul_a = 32'(err_reg);
                mul_b = $signed({1'b0, tick_reg});
            end
            MUL_KI:
            begin
                mul_a = integ_sel;
                mul_b = $signed({1'b0, ki_sel});
            end
            MUL_KP:
            begin
                mul_a = 32'(err_reg);
                mul_b = $signed({1'b0, kp_sel});
            end
            MUL_KD:
            begin
                mul_a = 32'(rate_sel);
                mul_b = $signed({1'b0, kd_sel});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_a_ext = 49'(mul_a);
    assign mul_b_ext = 49'(mul_b);
    assign prod_next = cmd.mul_en ? (mul_a_ext * mul_b_ext) : prod_reg;

    // quotient by 25: estimate is exact or one low
    assign q_est     = prod_reg[35:20];
    assign q25       = 21'({q_est, 4'b0}) + 21'({q_est, 3'b0}) + 21'(q_est);
    assign rem       = {1'b0, num_abs} - q25;
    assign quot_next = cmd.quot_en ? (q_est + 16'(rem >= 21'd25)) : quot_reg;

    // angle error
    assign ref_pos   = $signed({1'b0, quot_reg});
    assign ref_val   = dev_neg ? -ref_pos : ref_pos;
    assign ref_ext   = 18'(ref_val);
    assign angle_ext = 18'(angle_sel);
    assign err_next  = cmd.err_en ? (ref_ext - angle_ext) : err_reg;

    // integrator with symmetric clamp, cleared when disarmed
    assign delta     = prod_reg[33:8];
    assign integ_sum = 33'(integ_sel) + 33'(delta);
    assign lim_pos   = $signed({3'b0, lim_sel, 12'b0});
    assign lim_neg   = -lim_pos;

    always_comb
    begin
        if (integ_sum > lim_pos)
        begin
            integ_clamped = lim_pos;
        end
        else if (integ_sum < lim_neg)
        begin
            integ_clamped = lim_neg;
        end
        else
        begin
            integ_clamped = integ_sum;
        end
        integ_next = armed ? integ_clamped[31:0] : '0;
    end

    // torque accumulator: ki*I + 4096*(kp*e - kd*rate)
    assign prod_ext = 50'(prod_reg);
    assign prod_sh  = $signed({prod_reg[37:0], 12'b0});

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_sh;
            ACC_SUB:  acc_next = acc_reg - prod_sh;
            default:  acc_next = acc_reg;
        endcase
    end

    assign torque_wide = acc_reg[49:20];

    always_comb
    begin
        if (torque_wide > 30'sd8388607)
        begin
            torque_next = 24'sh7fffff;
        end
        else if (torque_wide < -30'sd8388608)
        begin
            torque_next = 24'sh800000;
        end
        else
        begin
            torque_next = torque_wide[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg[AXIS_ROLL]  <= '0;
            integ_reg[AXIS_PITCH] <= '0;
            integ_reg[AXIS_YAW]   <= '0;
        end
        else if (cmd.integ_en)
        begin
            integ_reg[cmd.axis] <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            roll_w_reg  <= rc_roll_width;
            pitch_w_reg <= rc_pitch_width;
            thr_w_reg   <= rc_throttle_width;
            yaw_w_reg   <= rc_yaw_width;
            roll_a_reg  <= roll_angle;
            pitch_a_reg <= pitch_angle;
            yaw_a_reg   <= yaw_angle;
            roll_r_reg  <= roll_rate;
            pitch_r_reg <= pitch_rate;
            yaw_r_reg   <= yaw_rate;
            tick_reg    <= tick_length;
        end
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        err_reg  <= err_next;
        acc_reg  <= acc_next;
        if (cmd.torque_en)
        begin
            torque_reg[cmd.axis] <= torque_next;
        end
        if (cmd.out_load)
        begin
            torque_roll_reg    <= armed ? torque_reg[AXIS_ROLL]  : '0;
            torque_pitch_reg   <= armed ? torque_reg[AXIS_PITCH] : '0;
            torque_yaw_reg     <= armed ? torque_reg[AXIS_YAW]   : '0;
            motors_enabled_reg <= armed;
            throttle_out_reg   <= thr_w_reg;
        end
    end

    assign torque_roll    = torque_roll_reg;
    assign torque_pitch   = torque_pitch_reg;
    assign torque_yaw     = torque_yaw_reg;
    assign motors_enabled = motors_enabled_reg;
    assign throttle_out   = throttle_out_reg;

endmodule

### rtl/core/apr_ctrl.sv
// ----------------------------------------------------------------------------
// apr_ctrl
// sequencer: ten micro-steps per axis over three axes, then result hand-off
// ----------------------------------------------------------------------------
`include "attitude_pi_rate_controller_top_defines.svh"

module apr_ctrl
    import apr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    localparam logic [3:0] STEP_RECIP  = 4'd0;
    localparam logic [3:0] STEP_QUOT   = 4'd1;
    localparam logic [3:0] STEP_ERR    = 4'd2;
    localparam logic [3:0] STEP_TICK   = 4'd3;
    localparam logic [3:0] STEP_INTEG  = 4'd4;
    localparam logic [3:0] STEP_KI     = 4'd5;
    localparam logic [3:0] STEP_KP     = 4'd6;
    localparam logic [3:0] STEP_KD     = 4'd7;
    localparam logic [3:0] STEP_SUB    = 4'd8;
    localparam logic [3:0] STEP_TORQUE = 4'd9;

    logic [1:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    axis_t      axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        axis_next  = axis_reg;

        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.mul_op    = MUL_RECIP;
        cmd.acc_op    = ACC_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_RUN;
                    step_next   = STEP_RECIP;
                    axis_next   = AXIS_ROLL;
                end
            end
            ST_RUN:
            begin
                unique case (step_reg)
                    STEP_RECIP:
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_RECIP;
                    end
                    STEP_QUOT:   cmd.quot_en = 1'b1;
                    STEP_ERR:    cmd.err_en  = 1'b1;
                    STEP_TICK:
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_TICK;
                    end
                    STEP_INTEG:  cmd.integ_en = 1'b1;
                    STEP_KI:
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_KI;
                    end
                    STEP_KP:
                    begin
                        cmd.acc_op = ACC_LOAD;
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_KP;
                    end
                    STEP_KD:
                    begin
                        cmd.acc_op = ACC_ADD;
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_KD;
                    end
                    STEP_SUB:    cmd.acc_op    = ACC_SUB;
                    STEP_TORQUE: cmd.torque_en = 1'b1;
                    default:     cmd.acc_op    = ACC_HOLD;
                endcase

                if (step_reg == STEP_TORQUE)
                begin
                    step_next = STEP_RECIP;
                    if (axis_reg == AXIS_YAW)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_LOAD:
            begin
                // wait until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RECIP;
            axis_reg      <= AXIS_ROLL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `APR_ASSERT_NOW(a_load_free, cmd.out_load, !out_valid_reg || !out_stall, "held result overwritten")
    `APR_ASSERT_NEXT(a_accept_start, in_valid && !in_stall, state_reg == ST_RUN && step_reg == STEP_RECIP && axis_reg == AXIS_ROLL, "item did not start at roll step zero")
    `APR_ASSERT_NOW(a_valid_rise, $rose(out_valid_reg), $past(state_reg) == ST_LOAD, "result appeared outside hand-off")
    `APR_ASSERT_NOW(a_run_range, state_reg == ST_RUN, axis_reg <= AXIS_YAW && step_reg <= STEP_TORQUE, "sequencer out of range")

endmodule
